// ----- hw/rtl/radix_digit_converter_top_macros.svh -----
// Assertion macros shared by the radix digit converter modules.
`ifndef RADIX_DIGIT_CONVERTER_TOP_MACROS_SVH
`define RADIX_DIGIT_CONVERTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Checks a property at every clock edge outside reset.
`define RDC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("rdc check failed");
// Checks that a condition in one cycle implies another in the next cycle.
`define RDC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rdc check failed");
`else
`define RDC_ASSERT(lbl, prop)
`define RDC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/rdc_pkg.sv -----
// Shared constants, types and functions of the radix digit converter.
package rdc_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int BASE_W          = 6;
	localparam int CHAR_W          = 7;

	localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
	localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
	localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;

	localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;
	localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'd55;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic div_step;
		logic push;
		logic rd;
		logic out_load;
		logic pop;
	} rdc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_done;
		logic quot_zero;
		logic cnt_one;
	} rdc_sts_t;

	// Maps a digit 0..35 to its ASCII character.
	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [BASE_W-1:0] d);
		logic [CHAR_W-1:0] d_ext;
		d_ext = {1'b0, d};
		if (d < 6'd10) begin
			return CHAR_ZERO + d_ext;
		end
		return CHAR_LETTER + d_ext;
	endfunction

	// Clamps a written base into the supported range.
	function automatic logic [BASE_W-1:0] base_sat(input logic [BASE_W-1:0] b);
		if (b < BASE_MIN) begin
			return BASE_MIN;
		end
		if (b > BASE_MAX) begin
			return BASE_MAX;
		end
		return b;
	endfunction

endpackage

// ----- hw/rtl/rdc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/rdc_datapath.sv -----
// Datapath: base register, bit-serial divider, digit stack and output register.
module rdc_datapath #(
	parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        base_we,
	input  logic [rdc_pkg::BASE_W-1:0]  base_wdata,
	input  logic [VALUE_WIDTH-1:0]      value,
	input  rdc_pkg::rdc_cmd_t           cmd,
	output rdc_pkg::rdc_sts_t           sts,
	output logic [rdc_pkg::CHAR_W-1:0]  digit_char,
	output logic                        last
);

	localparam int AW = $clog2(VALUE_WIDTH);
	localparam int CW = $clog2(VALUE_WIDTH + 1);
	localparam int BW = $clog2(VALUE_WIDTH);

	logic [rdc_pkg::BASE_W-1:0] base_q;
	logic [VALUE_WIDTH-1:0]     val_q;
	logic [rdc_pkg::BASE_W-1:0] rem_q;
	logic [BW-1:0]              bit_q;
	logic [CW-1:0]              cnt_q;
	logic [rdc_pkg::CHAR_W-1:0] char_q;
	logic                       last_q;

	logic [rdc_pkg::BASE_W:0]   rem_sh;
	logic [rdc_pkg::BASE_W:0]   rem_sub;
	logic                       q_bit;
	logic [CW-1:0]              cnt_m1;
	logic [rdc_pkg::CHAR_W-1:0] ram_rdata;

	// Base register, clamped on write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= rdc_pkg::BASE_RESET;
		end else if (base_we) begin
			base_q <= rdc_pkg::base_sat(base_wdata);
		end
	end

	// One restoring division step: shift in the next dividend bit, subtract if possible.
	always_comb begin
		rem_sh  = {rem_q, val_q[VALUE_WIDTH-1]};
		rem_sub = rem_sh - {1'b0, base_q};
		q_bit   = (rem_sh >= {1'b0, base_q});
	end

	// Dividend, remainder and bit counter.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= value;
			rem_q <= '0;
			bit_q <= BW'(VALUE_WIDTH - 1);
		end else if (cmd.div_step) begin
			val_q <= {val_q[VALUE_WIDTH-2:0], q_bit};
			rem_q <= q_bit ? rem_sub[rdc_pkg::BASE_W-1:0] : rem_sh[rdc_pkg::BASE_W-1:0];
			bit_q <= bit_q - BW'(1);
		end else if (cmd.push) begin
			rem_q <= '0;
			bit_q <= BW'(VALUE_WIDTH - 1);
		end
	end

	// Digit count, which is also the stack pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.push) begin
			cnt_q <= cnt_q + CW'(1);
		end else if (cmd.pop) begin
			cnt_q <= cnt_m1;
		end
	end

	assign cnt_m1 = cnt_q - CW'(1);

	// Digit stack: remainders pushed least significant first, read back in reverse.
	rdc_ram #(
		.WIDTH (rdc_pkg::CHAR_W),
		.DEPTH (VALUE_WIDTH)
	) u_stack (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (cnt_q[AW-1:0]),
		.wdata (rdc_pkg::digit_to_char(rem_q)),
		.re    (cmd.rd),
		.raddr (cnt_m1[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Output register holding the request shown to the receiver.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			char_q <= ram_rdata;
			last_q <= sts.cnt_one;
		end
	end

	assign sts.div_done  = (bit_q == '0);
	assign sts.quot_zero = (val_q == '0);
	assign sts.cnt_one   = (cnt_q == CW'(1));
	assign digit_char    = char_q;
	assign last          = last_q;

endmodule

// ----- hw/rtl/rdc_ctrl.sv -----
// Controller state machine sequencing division, stacking and emission.
`include "radix_digit_converter_top_macros.svh"

module rdc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  rdc_pkg::rdc_sts_t sts,
	output rdc_pkg::rdc_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_PUSH = 3'd2;
	localparam logic [2:0] S_READ = 3'd3;
	localparam logic [2:0] S_LOAD = 3'd4;
	localparam logic [2:0] S_SHOW = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = S_PUSH;
				end
			end
			S_PUSH: begin
				cmd.push = 1'b1;
				state_d  = sts.quot_zero ? S_READ : S_DIV;
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_LOAD;
			end
			S_LOAD: begin
				cmd.out_load = 1'b1;
				state_d      = S_SHOW;
			end
			S_SHOW: begin
				if (!out_stall) begin
					cmd.pop = 1'b1;
					state_d = sts.cnt_one ? S_IDLE : S_READ;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_SHOW);

	// A new value is never taken while a digit is still on offer.
	`RDC_ASSERT(a_no_overlap, !(out_valid && !in_stall))
	// The final division step always leads to a push.
	`RDC_ASSERT_NEXT(a_div_to_push, state_q == S_DIV && sts.div_done, state_q == S_PUSH)
	// Taking the final digit returns the block to idle.
	`RDC_ASSERT_NEXT(a_last_to_idle, out_valid && !out_stall && sts.cnt_one, !in_stall)

endmodule

// ----- hw/rtl/radix_digit_converter_top.sv -----
// Top level of the radix digit converter.
//
// Converts an unsigned VALUE_WIDTH-bit value to the base held in the base register
// (2 to 36) and emits one ASCII character per digit, most significant first.
// The input channel (in_valid, in_stall, value) takes one value at a time; in_stall
// stays high from acceptance until the final digit has been taken.
// The output channel (out_valid, out_stall, digit_char, last) delivers one request
// per digit; last is high on the final, least significant digit. A zero value gives
// the single character '0'.
// Each digit comes from the bit-serial divider, which yields one quotient bit per
// cycle, and is pushed onto the digit stack; emission then reads the digits back
// through the stack's registered read and the output register, waiting while the
// receiver stalls. While out_stall is high the current digit is held unchanged.
// The base register is written with base_we and base_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce. Values
// below 2 or above 36 are clamped. Reset sets the base to 10 and returns the block
// to idle, dropping any conversion in progress.
module radix_digit_converter_top #(
	parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       base_we,
	input  logic [rdc_pkg::BASE_W-1:0] base_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [VALUE_WIDTH-1:0]     value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [rdc_pkg::CHAR_W-1:0] digit_char,
	output logic                       last
);

	rdc_pkg::rdc_cmd_t cmd;
	rdc_pkg::rdc_sts_t sts;

	// Sequencer.
	rdc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Divider, digit stack and output register.
	rdc_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.base_we    (base_we),
		.base_wdata (base_wdata),
		.value      (value),
		.cmd        (cmd),
		.sts        (sts),
		.digit_char (digit_char),
		.last       (last)
	);

endmodule
